FILE: rtl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg: shared types and constants of the sine/cosine polynomial unit
// Fixed-point formats, reduction constants, Horner coefficients per cell and
// the bus carried from cell to cell.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int ANGLE_FRAC_BITS  = 16;
  localparam int RESULT_FRAC_BITS = 16;

  localparam int ANGLE_W  = 32;
  localparam int RESULT_W = 18;
  localparam int Q_W      = 32;
  localparam int RW_W     = 40;
  localparam int P_W      = 66;
  localparam int K_W      = 33 - ANGLE_FRAC_BITS;
  localparam int A_SHIFT  = 32 - ANGLE_FRAC_BITS;
  localparam int NUM_CELLS = 4;

  localparam logic signed [P_W-1:0]  TWO_OVER_PI = P_W'(64'hA2F9836E);
  localparam logic signed [P_W-1:0]  K_ROUND     = P_W'(1) <<< (ANGLE_FRAC_BITS + 31);
  localparam logic signed [RW_W-1:0] HALF_PI_HI  = RW_W'(64'h1921FB544);
  localparam logic signed [63:0]     HALF_PI_LO  = 64'sh42D1846A;

  localparam logic signed [63:0] Q30_ONE_W = 64'sd1 <<< 30;
  localparam logic signed [Q_W-1:0] Q30_ONE = Q_W'(Q30_ONE_W);
  localparam logic signed [Q_W-1:0] R_2     = Q_W'((Q30_ONE_W + 1) / 2);
  localparam logic signed [Q_W-1:0] R_6     = Q_W'((Q30_ONE_W + 3) / 6);
  localparam logic signed [Q_W-1:0] R_24    = Q_W'((Q30_ONE_W + 12) / 24);
  localparam logic signed [Q_W-1:0] R_120   = Q_W'((Q30_ONE_W + 60) / 120);
  localparam logic signed [Q_W-1:0] R_720   = Q_W'((Q30_ONE_W + 360) / 720);
  localparam logic signed [Q_W-1:0] R_5040  = Q_W'((Q30_ONE_W + 2520) / 5040);
  localparam logic signed [Q_W-1:0] R_40320 = Q_W'((Q30_ONE_W + 20160) / 40320);

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic                  valid;
    quad_t                 quad;
    logic signed [Q_W-1:0] r;
    logic signed [Q_W-1:0] r2;
    logic signed [Q_W-1:0] ts;
    logic signed [Q_W-1:0] tc;
  } cell_bus_t;

  typedef struct packed {
    logic signed [Q_W-1:0] ks;
    logic signed [Q_W-1:0] kc;
    logic                  s_use_r;
    logic                  s_neg;
  } cell_coef_t;

  localparam cell_coef_t CELL_COEF [NUM_CELLS] = '{
    '{ks: R_120,   kc: R_720,   s_use_r: 1'b0, s_neg: 1'b1},
    '{ks: R_6,     kc: R_24,    s_use_r: 1'b0, s_neg: 1'b1},
    '{ks: Q30_ONE, kc: R_2,     s_use_r: 1'b0, s_neg: 1'b1},
    '{ks: '0,      kc: Q30_ONE, s_use_r: 1'b1, s_neg: 1'b0}
  };

  // Q.30 product, rounded to nearest with ties upward
  function automatic logic signed [Q_W+1:0] mul_q30(input logic signed [Q_W-1:0] a,
                                                    input logic signed [Q_W-1:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return p[63:30];
  endfunction

endpackage

FILE: rtl/scp_reduce.sv
// ----------------------------------------------------------------------------
// scp_reduce: quadrant reduction front end
// Find the quadrant and the Q.30 remainder of the angle, square it and load
// the starting Horner terms for the cell chain.
// ----------------------------------------------------------------------------
module scp_reduce (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [scp_pkg::ANGLE_W-1:0]   in_angle,
  output scp_pkg::cell_bus_t                   bus_o
);
  import scp_pkg::*;

  // stage 1: quadrant index
  logic                  v1_r;
  logic signed [P_W-1:0] p1_nxt;
  logic signed [K_W-1:0] k1_r;
  logic signed [ANGLE_W-1:0] a1_r;

  // stage 2: pi/2 multiples
  logic                   v2_r;
  quad_t                  q2_r;
  logic signed [RW_W-1:0] ash2_r, khi2_r, klo2_r;
  logic signed [63:0]     klo_full;
  logic signed [RW_W-1:0] ash_nxt, khi_nxt;

  // stage 3: remainder
  logic                   v3_r;
  quad_t                  q3_r;
  logic signed [Q_W-1:0]  r3_r;
  logic signed [RW_W-1:0] rw_nxt;

  // stage 4: square
  cell_bus_t              bus_r;
  logic signed [Q_W+1:0]  r2_nxt;

  assign p1_nxt  = P_W'(in_angle) * TWO_OVER_PI + K_ROUND;
  assign ash_nxt = RW_W'(a1_r) <<< A_SHIFT;
  assign khi_nxt = RW_W'(k1_r) * HALF_PI_HI;
  assign klo_full = 64'(k1_r) * HALF_PI_LO + 64'sd2147483648;
  assign rw_nxt  = ash2_r - khi2_r - klo2_r + RW_W'(2);
  assign r2_nxt  = mul_q30(r3_r, r3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      bus_r.valid <= 1'b0;
    end else if (en) begin
      v1_r       <= in_valid;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
      a1_r       <= in_angle;
      k1_r       <= p1_nxt[ANGLE_FRAC_BITS+32 +: K_W];
      q2_r       <= quad_t'(k1_r[1:0]);
      ash2_r     <= ash_nxt;
      khi2_r     <= khi_nxt;
      klo2_r     <= RW_W'(signed'(klo_full[63:32]));
      q3_r       <= q2_r;
      r3_r       <= rw_nxt[Q_W+1:2];
      bus_r.valid <= v3_r;
      bus_r.quad <= q3_r;
      bus_r.r    <= r3_r;
      bus_r.r2   <= r2_nxt[Q_W-1:0];
      bus_r.ts   <= R_5040;
      bus_r.tc   <= R_40320;
    end
  end

  assign bus_o = bus_r;

endmodule

FILE: rtl/scp_cell.sv
// ----------------------------------------------------------------------------
// scp_cell: one Horner step
// Advance the sine and cosine Horner terms by one coefficient and hand the
// remainder, its square and the quadrant on to the next cell.
// ----------------------------------------------------------------------------
module scp_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  scp_pkg::cell_coef_t coef,
  input  scp_pkg::cell_bus_t  bus_i,
  output scp_pkg::cell_bus_t  bus_o
);
  import scp_pkg::*;

  cell_bus_t             bus_r, bus_nxt;
  logic signed [Q_W-1:0] op_s;
  logic signed [Q_W+1:0] ms, mc, s_sum, c_sum;

  always_comb begin
    op_s  = coef.s_use_r ? bus_i.r : bus_i.r2;
    ms    = mul_q30(op_s, bus_i.ts);
    mc    = mul_q30(bus_i.r2, bus_i.tc);
    s_sum = (Q_W+2)'(coef.ks) + (coef.s_neg ? -ms : ms);
    c_sum = (Q_W+2)'(coef.kc) - mc;
    bus_nxt       = bus_i;
    bus_nxt.ts    = s_sum[Q_W-1:0];
    bus_nxt.tc    = c_sum[Q_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.valid <= 1'b0;
    end else if (en) begin
      bus_r <= bus_nxt;
    end
  end

  assign bus_o = bus_r;

endmodule

FILE: rtl/scp_finish.sv
// ----------------------------------------------------------------------------
// scp_finish: quadrant selection and output register
// Swap and negate the polynomial values by quadrant, round to the result
// format, clamp to unit range and hold the request until it is taken.
// ----------------------------------------------------------------------------
module scp_finish (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  scp_pkg::cell_bus_t                  bus_i,
  output logic                                out_valid,
  output logic signed [scp_pkg::RESULT_W-1:0] out_sine,
  output logic signed [scp_pkg::RESULT_W-1:0] out_cosine
);
  import scp_pkg::*;

  localparam int RND_SH = 30 - RESULT_FRAC_BITS;
  localparam int F_W    = Q_W + 2;
  localparam logic signed [F_W-1:0] HALF_R  = (RND_SH == 0) ? '0 : F_W'(1) <<< (RND_SH - 1);
  localparam logic signed [F_W-1:0] LIM     = F_W'(1) <<< RESULT_FRAC_BITS;
  localparam logic signed [F_W-1:0] OUT_MAX = F_W'(131071);
  localparam logic signed [F_W-1:0] OUT_MIN = -F_W'(131072);

  function automatic logic signed [RESULT_W-1:0] fin(input logic signed [F_W-1:0] v);
    logic signed [F_W-1:0] x;
    x = (v + HALF_R) >>> RND_SH;
    if (x > LIM) x = LIM;
    if (x < -LIM) x = -LIM;
    if (x > OUT_MAX) x = OUT_MAX;
    if (x < OUT_MIN) x = OUT_MIN;
    return x[RESULT_W-1:0];
  endfunction

  logic                  valid_r;
  logic signed [RESULT_W-1:0] sine_r, cosine_r;
  logic signed [F_W-1:0] sp, cp, s_sel, c_sel;

  always_comb begin
    sp = F_W'(bus_i.ts);
    cp = F_W'(bus_i.tc);
    case (bus_i.quad)
      QUAD_0: begin
        s_sel = sp;
        c_sel = cp;
      end
      QUAD_1: begin
        s_sel = cp;
        c_sel = -sp;
      end
      QUAD_2: begin
        s_sel = -sp;
        c_sel = -cp;
      end
      default: begin
        s_sel = -cp;
        c_sel = sp;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= bus_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sine_r   <= fin(s_sel);
      cosine_r <= fin(c_sel);
    end
  end

  assign out_valid  = valid_r;
  assign out_sine   = sine_r;
  assign out_cosine = cosine_r;

endmodule

FILE: rtl/sine_cosine_poly_unit.sv
// ----------------------------------------------------------------------------
// sine_cosine_poly_unit: fixed-point sine and cosine
// Takes one Q16.16 angle in radians per request and returns its sine and
// cosine in Q2.16. A fresh angle is taken every clock cycle while results
// are being taken; each request passes through four reduction stages, four
// Horner cells and one output register. The whole pipeline moves as one: a
// result that waits on out_ready holds every stage.
// ----------------------------------------------------------------------------
module sine_cosine_poly_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [scp_pkg::ANGLE_W-1:0]  in_angle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [scp_pkg::RESULT_W-1:0] out_sine,
  output logic signed [scp_pkg::RESULT_W-1:0] out_cosine
);
  import scp_pkg::*;

  logic      en;
  cell_bus_t chain [NUM_CELLS+1];

  // advance whenever the output slot is free or being emptied
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  scp_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_angle (in_angle),
    .bus_o    (chain[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    scp_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .coef  (CELL_COEF[i]),
      .bus_i (chain[i]),
      .bus_o (chain[i+1])
    );
  end

  scp_finish u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .bus_i      (chain[NUM_CELLS]),
    .out_valid  (out_valid),
    .out_sine   (out_sine),
    .out_cosine (out_cosine)
  );

endmodule

FILE: rtl/scp_checker.sv
// ----------------------------------------------------------------------------
// scp_checker: port-level checks of the sine/cosine polynomial unit
// Watch the handshake, the stall behaviour and the result range.
// ----------------------------------------------------------------------------
module scp_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic signed [scp_pkg::ANGLE_W-1:0]  in_angle,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [scp_pkg::RESULT_W-1:0] out_sine,
  input logic signed [scp_pkg::RESULT_W-1:0] out_cosine
);
  import scp_pkg::*;

  localparam logic signed [RESULT_W:0] LIM = (RESULT_W+1)'(1) <<< RESULT_FRAC_BITS;

  logic unused_in;
  assign unused_in = in_valid ^ (^in_angle);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result request present straight after reset");

  a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output slot");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sine) && $stable(out_cosine))
    else $error("stalled result request changed");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (RESULT_W+1)'(out_sine) <= LIM && (RESULT_W+1)'(out_sine) >= -LIM &&
                  (RESULT_W+1)'(out_cosine) <= LIM && (RESULT_W+1)'(out_cosine) >= -LIM)
    else $error("result outside unit range");

endmodule

bind sine_cosine_poly_unit scp_checker u_scp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_angle   (in_angle),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_sine   (out_sine),
  .out_cosine (out_cosine)
);
